// File: design/i2cm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, command codes and phase tables for the I2C master sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int PHASE_TICKS_W = 16;
    localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RESET = 16'd720;

    // command codes carried in kind
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_SEND  = 3'd3;
    localparam logic [2:0] CMD_RECV  = 3'd4;
    localparam logic [2:0] CMD_SACK  = 3'd5;
    localparam logic [2:0] CMD_RACK  = 3'd6;
    localparam logic [2:0] CMD_BAD   = 3'd7;

    // pin actions
    localparam logic [2:0] ACT_SDA_LOW  = 3'd0;
    localparam logic [2:0] ACT_SDA_HIGH = 3'd1;
    localparam logic [2:0] ACT_SCL_LOW  = 3'd2;
    localparam logic [2:0] ACT_SCL_HIGH = 3'd3;
    localparam logic [2:0] ACT_SAMPLE   = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] tx_byte;
        logic       tx_ack;
        logic       sda_in;
    } tick_item_t;

    typedef struct packed {
        logic       scl_drive;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       rx_ack;
        logic       rejected;
    } tick_result_t;

    function automatic logic [4:0] phase_count(input logic [2:0] cmd);
        logic [4:0] cnt;
        begin
            cnt = 5'd0;
            unique case (cmd)
                CMD_START: cnt = 5'd4;
                CMD_STOP:  cnt = 5'd3;
                CMD_SEND:  cnt = 5'd24;
                CMD_RECV:  cnt = 5'd25;
                CMD_SACK:  cnt = 5'd3;
                CMD_RACK:  cnt = 5'd4;
                default:   cnt = 5'd0;
            endcase
            return cnt;
        end
    endfunction

    // sub is the position inside a three-phase bit slot, bit_idx the bit number
    function automatic logic [2:0] phase_action(
        input logic [2:0] cmd,
        input logic [4:0] ph,
        input logic [1:0] sub,
        input logic [2:0] bit_idx,
        input logic [7:0] shift_data,
        input logic       ack_level
    );
        logic [2:0] act;
        begin
            act = ACT_SDA_HIGH;
            unique case (cmd)
                CMD_START:
                begin
                    unique case (ph[1:0])
                        2'd0:    act = ACT_SDA_HIGH;
                        2'd1:    act = ACT_SCL_HIGH;
                        2'd2:    act = ACT_SDA_LOW;
                        default: act = ACT_SCL_LOW;
                    endcase
                end
                CMD_STOP:
                begin
                    unique case (ph)
                        5'd0:    act = ACT_SDA_LOW;
                        5'd1:    act = ACT_SCL_HIGH;
                        default: act = ACT_SDA_HIGH;
                    endcase
                end
                CMD_SEND:
                begin
                    if (sub == 2'd0)
                        act = shift_data[3'd7 - bit_idx] ? ACT_SDA_HIGH : ACT_SDA_LOW;
                    else if (sub == 2'd1)
                        act = ACT_SCL_HIGH;
                    else
                        act = ACT_SCL_LOW;
                end
                CMD_RECV:
                begin
                    if (ph == 5'd0)
                        act = ACT_SDA_HIGH;
                    else if (sub == 2'd0)
                        act = ACT_SCL_HIGH;
                    else if (sub == 2'd1)
                        act = ACT_SAMPLE;
                    else
                        act = ACT_SCL_LOW;
                end
                CMD_SACK:
                begin
                    if (ph == 5'd0)
                        act = ack_level ? ACT_SDA_HIGH : ACT_SDA_LOW;
                    else if (ph == 5'd1)
                        act = ACT_SCL_HIGH;
                    else
                        act = ACT_SCL_LOW;
                end
                CMD_RACK:
                begin
                    unique case (ph[1:0])
                        2'd0:    act = ACT_SDA_HIGH;
                        2'd1:    act = ACT_SCL_HIGH;
                        2'd2:    act = ACT_SAMPLE;
                        default: act = ACT_SCL_LOW;
                    endcase
                end
                default: act = ACT_SDA_HIGH;
            endcase
            return act;
        end
    endfunction

endpackage
`default_nettype wire

// File: design/i2cm_seq_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_seq_core
// Sequencer state and the one-tick update: command start, pin action,
// sampling, phase timing and result forming.
// ----------------------------------------------------------------------------
module i2cm_seq_core
    import i2cm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     step,
    input  wire logic [PHASE_TICKS_W-1:0] phase_ticks,
    input  wire tick_item_t               item,
    output tick_result_t                  result
);

    logic [2:0]               active_reg, active_next;
    logic [4:0]               phase_reg, phase_next;
    logic [PHASE_TICKS_W-1:0] tick_reg, tick_next;
    logic [7:0]               shift_reg, shift_next;
    logic                     scl_reg, scl_next;
    logic                     sda_reg, sda_next;
    logic                     ack_reg, ack_next;
    logic [1:0]               sub_reg, sub_next;
    logic [2:0]               bit_reg, bit_next;

    logic                     is_cmd;
    logic                     start;
    logic [2:0]               cmd;
    logic [4:0]               ph;
    logic [4:0]               ph_inc;
    logic [PHASE_TICKS_W-1:0] tc;
    logic [1:0]               sub;
    logic [2:0]               bit_idx;
    logic [7:0]               shift_pre;
    logic                     ack_pre;
    logic [2:0]               act;
    logic [PHASE_TICKS_W:0]   plen;
    logic                     phase_end;
    logic                     done;

    always_comb
    begin
        is_cmd    = (item.kind != CMD_NONE) && (item.kind != CMD_BAD);
        start     = is_cmd && (active_reg == CMD_NONE);
        cmd       = start ? item.kind : active_reg;
        ph        = start ? 5'd0 : phase_reg;
        tc        = start ? '0 : tick_reg;
        sub       = start ? 2'd0 : sub_reg;
        bit_idx   = start ? 3'd0 : bit_reg;
        shift_pre = shift_reg;
        if (start && item.kind == CMD_SEND)
            shift_pre = item.tx_byte;
        else if (start && item.kind == CMD_RECV)
            shift_pre = 8'd0;
        ack_pre = (start && item.kind == CMD_SACK) ? item.tx_ack : ack_reg;

        plen = (phase_ticks == '0) ? {{PHASE_TICKS_W{1'b0}}, 1'b1}
                                   : {1'b0, phase_ticks};
        act  = phase_action(cmd, ph, sub, bit_idx, shift_pre, ack_pre);

        active_next = active_reg;
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        shift_next  = shift_pre;
        ack_next    = ack_pre;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        sub_next    = sub_reg;
        bit_next    = bit_reg;
        phase_end   = 1'b0;
        done        = 1'b0;
        ph_inc      = ph + 5'd1;

        if (cmd != CMD_NONE)
        begin
            active_next = cmd;
            phase_next  = ph;
            sub_next    = sub;
            bit_next    = bit_idx;
            if (tc == '0)
            begin
                unique case (act)
                    ACT_SDA_LOW:  sda_next = 1'b0;
                    ACT_SDA_HIGH: sda_next = 1'b1;
                    ACT_SCL_LOW:  scl_next = 1'b0;
                    ACT_SCL_HIGH: scl_next = 1'b1;
                    default:
                    begin
                        if (cmd == CMD_RECV)
                            shift_next = {shift_pre[6:0], item.sda_in};
                        else
                            ack_next = item.sda_in;
                    end
                endcase
            end
            phase_end = ({1'b0, tc} + 1'b1) >= plen;
            if (phase_end)
            begin
                tick_next  = '0;
                phase_next = ph_inc;
                // receive byte: the release phase sits ahead of the bit slots
                if (!(cmd == CMD_RECV && ph == 5'd0))
                begin
                    if (sub == 2'd2)
                    begin
                        sub_next = 2'd0;
                        bit_next = bit_idx + 3'd1;
                    end
                    else
                    begin
                        sub_next = sub + 2'd1;
                    end
                end
                if (ph_inc >= phase_count(cmd))
                begin
                    done        = 1'b1;
                    active_next = CMD_NONE;
                    phase_next  = 5'd0;
                end
            end
            else
            begin
                tick_next = tc + 1'b1;
            end
        end

        result.scl_drive = scl_next;
        result.sda_drive = sda_next;
        result.busy_res  = (active_next != CMD_NONE);
        result.done_res  = done;
        result.rx_byte   = (done && cmd == CMD_RECV) ? shift_next : 8'd0;
        result.rx_ack    = done && (cmd == CMD_RACK) && ack_next;
        result.rejected  = is_cmd && (active_reg != CMD_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= CMD_NONE;
            phase_reg  <= 5'd0;
            tick_reg   <= '0;
            shift_reg  <= 8'd0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            ack_reg    <= 1'b0;
            sub_reg    <= 2'd0;
            bit_reg    <= 3'd0;
        end
        else if (step)
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            shift_reg  <= shift_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            ack_reg    <= ack_next;
            sub_reg    <= sub_next;
            bit_reg    <= bit_next;
        end
    end

endmodule
`default_nettype wire

// File: design/i2c_master_bit_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master line sequencer: one tick per input transaction, drives
// open-drain SCL/SDA through start, stop, byte and ack phase lists.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | tuser kind, tdata tx_byte / tx_ack / sda_in
//  m_axis    | out       | tdata scl, sda, busy, done, rx_byte, rx_ack, rejected
//  cfg       | in        | phase_ticks write, no read-back
//
//  one transaction is accepted every cycle while the output is not stalled
//  a transaction passes through the input register, then the sequencer update into the
//  output register
//  the sequencer state advances only when a tick moves into the output register
//  an output stall holds both stages; reset releases SCL and SDA and goes idle
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
    import i2cm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [15:0]              s_axis_tdata,  // tx_byte, tx_ack, sda_in
    input  wire logic [2:0]               s_axis_tuser,  // kind
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [15:0]                   m_axis_tdata,  // scl_drive, sda_drive,
                                                         // busy_res, done_res,
                                                         // rx_byte, rx_ack, rejected
    input  wire logic                     cfg_we,
    input  wire logic [PHASE_TICKS_W-1:0] cfg_wdata
);

    logic [PHASE_TICKS_W-1:0] phase_ticks_reg;
    logic                     in_valid_reg;
    tick_item_t               in_item_reg;
    logic                     out_valid_reg;
    tick_result_t             out_res_reg;
    tick_result_t             core_res;
    logic                     out_ready;
    logic                     step;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_ticks_reg <= PHASE_TICKS_RESET;
        else if (cfg_we)
            phase_ticks_reg <= cfg_wdata;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.kind    <= s_axis_tuser;
            in_item_reg.tx_byte <= s_axis_tdata[7:0];
            in_item_reg.tx_ack  <= s_axis_tdata[8];
            in_item_reg.sda_in  <= s_axis_tdata[9];
        end
    end

    i2cm_seq_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .phase_ticks (phase_ticks_reg),
        .item        (in_item_reg),
        .result      (core_res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_res_reg <= core_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00,
                            out_res_reg.rejected,
                            out_res_reg.rx_ack,
                            out_res_reg.rx_byte,
                            out_res_reg.done_res,
                            out_res_reg.busy_res,
                            out_res_reg.sda_drive,
                            out_res_reg.scl_drive};

endmodule
`default_nettype wire
